// ----- hw/rtl/ilp_pkg.sv -----
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types, constants and helper functions for the integer literal
// parser: request and result structs, parse state, base codes, digit decode.
// ----------------------------------------------------------------------------
package ilp_pkg;

  // Width of the signed result range; the output field is always 64 bits.
  localparam int VALUE_BITS = 64;
  localparam int OUT_BITS   = 64;
  // Headroom for magnitude * 16 + 35 before the range check.
  localparam int WIDE_BITS  = VALUE_BITS + 5;

  // Largest positive value in range
  localparam logic [VALUE_BITS-1:0] MAX_POS = {1'b0, {(VALUE_BITS-1){1'b1}}};

  // Base codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_DEC = 2'd0,
    MODE_BIN = 2'd1,
    MODE_OCT = 2'd2,
    MODE_HEX = 2'd3
  } mode_t;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;

  // Digit value of a character that is no digit in any base
  localparam logic [5:0] DIGIT_NONE = 6'd63;

  // Position counter saturates here
  localparam logic [1:0] POS_MAX = 2'd3;

  // Incoming request
  typedef struct packed {
    logic [7:0] symbol;
    logic [1:0] mode;
    logic       last;
  } in_t;

  // Outgoing result
  typedef struct packed {
    logic signed [OUT_BITS-1:0] value;
    logic                       overflow;
    logic                       digits_found;
  } out_t;

  // Running parse state for the current literal
  typedef struct packed {
    logic [1:0]            position;
    logic                  negative;
    logic [VALUE_BITS-1:0] magnitude;
    logic                  saturated;
    logic                  stopped;
    logic                  any_digit;
    logic [1:0]            base_latch;
  } state_t;

  localparam state_t STATE_RESET = '0;

  // Character to digit value; letters are worth 10 to 35
  function automatic logic [5:0] digit_value(input logic [7:0] c);
    logic [5:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = 6'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = 6'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      d = 6'(c - 8'h41 + 8'd10);
    end else begin
      d = DIGIT_NONE;
    end
    return d;
  endfunction

  // Base code to radix
  function automatic logic [4:0] radix_of(input logic [1:0] m);
    logic [4:0] r;
    unique case (m)
      MODE_BIN: r = 5'd2;
      MODE_OCT: r = 5'd8;
      MODE_HEX: r = 5'd16;
      default:  r = 5'd10;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/ilp_accum.sv -----
// ----------------------------------------------------------------------------
// ilp_accum
// Next-state logic for one character: base latch, sign and prefix handling,
// digit decode and the multiply-add with saturation. Also forms the result
// that is delivered when the character ends the literal.
// ----------------------------------------------------------------------------
module ilp_accum (
  input  ilp_pkg::state_t st,
  input  ilp_pkg::in_t    req,
  output ilp_pkg::state_t st_next,
  output ilp_pkg::out_t   res
);

  logic [1:0]                       base;
  logic [4:0]                       radix;
  logic [5:0]                       digit;
  logic                             do_acc;
  logic [ilp_pkg::VALUE_BITS-1:0]   limit;
  logic [ilp_pkg::WIDE_BITS-1:0]    mag_ext;
  logic [ilp_pkg::WIDE_BITS-1:0]    scaled;
  logic [ilp_pkg::WIDE_BITS-1:0]    wide;
  logic [ilp_pkg::VALUE_BITS-1:0]   signed_mag;

  // Base is taken from the first non-underscore character's mode
  assign base  = (st.position == 2'd0) ? req.mode : st.base_latch;
  assign radix = ilp_pkg::radix_of(base);
  assign digit = ilp_pkg::digit_value(req.symbol);

  // Saturation limit: one more on the negative side
  assign limit = ilp_pkg::MAX_POS + ilp_pkg::VALUE_BITS'(st.negative);

  // magnitude * radix + digit, as shifts and adds
  assign mag_ext = ilp_pkg::WIDE_BITS'(st.magnitude);
  always_comb begin
    unique case (base)
      ilp_pkg::MODE_BIN: scaled = mag_ext << 1;
      ilp_pkg::MODE_OCT: scaled = mag_ext << 3;
      ilp_pkg::MODE_HEX: scaled = mag_ext << 4;
      default:           scaled = (mag_ext << 3) + (mag_ext << 1);
    endcase
  end
  assign wide = scaled + ilp_pkg::WIDE_BITS'(digit);

  // Sign, prefix skipping and digit accumulation
  always_comb begin
    st_next            = st;
    st_next.base_latch = base;
    do_acc             = 1'b0;
    if (req.symbol != ilp_pkg::CH_UNDERSCORE) begin
      if (!st.stopped) begin
        if (base == ilp_pkg::MODE_DEC) begin
          if (st.position == 2'd0 &&
              (req.symbol == ilp_pkg::CH_MINUS || req.symbol == ilp_pkg::CH_PLUS)) begin
            st_next.negative = (req.symbol == ilp_pkg::CH_MINUS);
          end else begin
            do_acc = 1'b1;
          end
        end else begin
          if (st.position == 2'd0 && req.symbol == ilp_pkg::CH_MINUS) begin
            st_next.negative = 1'b1;
          end else if (st.position >= (st.negative ? 2'd3 : 2'd2)) begin
            do_acc = 1'b1;
          end
        end
      end
      if (st.position != ilp_pkg::POS_MAX) begin
        st_next.position = st.position + 2'd1;
      end
    end

    if (do_acc) begin
      if (6'(radix) <= digit) begin
        st_next.stopped = 1'b1;
      end else begin
        st_next.any_digit = 1'b1;
        if (st.saturated || wide > ilp_pkg::WIDE_BITS'(limit)) begin
          st_next.magnitude = limit;
          st_next.saturated = 1'b1;
        end else begin
          st_next.magnitude = wide[ilp_pkg::VALUE_BITS-1:0];
        end
      end
    end
  end

  // Result for a closing character
  assign signed_mag = st_next.negative ? (~st_next.magnitude + 1'b1) : st_next.magnitude;
  assign res.value        = ilp_pkg::OUT_BITS'($signed(signed_mag));
  assign res.overflow     = st_next.saturated;
  assign res.digits_found = st_next.any_digit;

endmodule

// ----- hw/rtl/int_literal_parser_top.sv -----
// ----------------------------------------------------------------------------
// int_literal_parser_top
// Integer literal parser: one character per request, one signed result per
// literal, delivered on the request marked last.
// ----------------------------------------------------------------------------
//  Channel | Signals                           | Payload
//  --------+-----------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data       | symbol, mode, last
//  out     | out_valid, out_ready, out_data    | value, overflow, digits_found
//
//  One character per cycle sustained unless a closing character waits for a
//  busy result slot; a result comes from the input, then the result register.
//  The character-to-character dependency is the parse state register, whose
//  update (shift-add and limit compare) is combinational.
//  Synchronous active-high reset clears the parse state and both valids.
//  A waiting result only stalls input when a closing character reaches the
//  core; other characters keep flowing.
// ----------------------------------------------------------------------------
module int_literal_parser_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ilp_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ilp_pkg::out_t  out_data
);

  logic            hold_valid;
  ilp_pkg::in_t    hold;
  ilp_pkg::state_t st;
  ilp_pkg::state_t st_next;
  ilp_pkg::out_t   res;
  logic            fire;

  // Held request may go when it makes no result or the result slot frees
  assign fire     = hold_valid && (!hold.last || !out_valid || out_ready);
  assign in_ready = !hold_valid || fire;

  ilp_accum u_accum (
    .st      (st),
    .req     (hold),
    .st_next (st_next),
    .res     (res)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      st         <= ilp_pkg::STATE_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (fire) begin
        st <= hold.last ? ilp_pkg::STATE_RESET : st_next;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (fire && hold.last) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= in_data;
    end
    if (fire && hold.last) begin
      out_data <= res;
    end
  end

  // Checks
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire && hold.last))
    else $error("result raised without a closing request");

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    (fire && hold.last) |=> (st.position == 2'd0 && !st.any_digit && !st.saturated))
    else $error("parse state not cleared after closing request");

  a_pos0_clean: assert property (@(posedge clk) disable iff (rst)
    (st.position == 2'd0) |-> (!st.negative && !st.stopped && !st.any_digit &&
                               st.magnitude == '0))
    else $error("parse state dirty before first character");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    st.saturated |-> (st.magnitude ==
                      ilp_pkg::MAX_POS + ilp_pkg::VALUE_BITS'(st.negative)))
    else $error("saturated magnitude off the limit");

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer literal parser. Character requests are
// queued by a stimulus process and driven with random gaps; a parse model in
// the bench predicts each literal's value, overflow and digit flag, and every
// result taken from the block is compared field by field with the oldest
// prediction. Stimulus runs a short directed set, then random literals
// (mostly well-formed, some at the 64-bit limits, some noise) under long,
// then no, then random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ilp_pkg::*;

  localparam int VB = VALUE_BITS;

  // Running state of the literal being parsed
  typedef struct packed {
    logic [1:0]    pos;
    logic          neg;
    logic [VB-1:0] mag;
    logic          sat;
    logic          halted;
    logic          seen_digit;
    logic [1:0]    base;
  } lit_state_t;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  in_valid  = 1'b0;
  logic  in_ready;
  in_t   in_data   = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  in_t        char_backlog[$];
  out_t       awaited_values[$];
  lit_state_t lit = '0;
  int         chars_queued = 0;
  int         err_count    = 0;
  bit         req_taken    = 1'b0;
  bit         calm         = 1'b0;
  bit         hold_req     = 1'b0;
  int         hold_left    = 0;
  out_t       got, want;
  out_t       fresh;

  // Literals sitting on the edges of the signed range
  string brink_text [8] = '{"9223372036854775807", "9223372036854775808",
                            "-9223372036854775808", "-9223372036854775809",
                            "0x7fffffffffffffff", "-0x8000000000000000",
                            "0X8000000000000000", "-0x8000000000000001"};
  mode_t brink_mode [8] = '{MODE_DEC, MODE_DEC, MODE_DEC, MODE_DEC,
                            MODE_HEX, MODE_HEX, MODE_HEX, MODE_HEX};

  int_literal_parser_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model --
  function automatic logic [5:0] char_weight(logic [7:0] c);
    if (c >= "0" && c <= "9") return 6'(c - "0");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 10);
    if (c >= "A" && c <= "Z") return 6'(c - "A" + 10);
    return 6'd63;
  endfunction

  function automatic int base_radix(logic [1:0] m);
    case (m)
      MODE_BIN: return 2;
      MODE_OCT: return 8;
      MODE_HEX: return 16;
      default:  return 10;
    endcase
  endfunction

  // Shift one digit into the magnitude, clamping at the signed limit
  function automatic void fold_digit(logic [7:0] c);
    logic [VB-1:0] w, radix, ceiling;
    w     = VB'(char_weight(c));
    radix = VB'(base_radix(lit.base));
    if (w >= radix) begin
      lit.halted = 1'b1;
      return;
    end
    lit.seen_digit = 1'b1;
    ceiling = MAX_POS + VB'(lit.neg);
    if (lit.sat || lit.mag > (ceiling - w) / radix) begin
      lit.mag = ceiling;
      lit.sat = 1'b1;
    end else begin
      lit.mag = lit.mag * radix + w;
    end
  endfunction

  // Advance the literal by one character; returns 1 when a result is due
  function automatic bit parse_char(in_t r, output out_t res);
    logic [VB-1:0] v;
    res = '0;
    if (lit.pos == 2'd0) lit.base = r.mode;
    if (r.symbol != CH_UNDERSCORE) begin
      if (!lit.halted) begin
        if (lit.base == MODE_DEC) begin
          if (lit.pos == 2'd0 && (r.symbol == CH_MINUS || r.symbol == CH_PLUS)) begin
            lit.neg = (r.symbol == CH_MINUS);
          end else begin
            fold_digit(r.symbol);
          end
        end else if (lit.pos == 2'd0 && r.symbol == CH_MINUS) begin
          lit.neg = 1'b1;
        end else if (lit.pos >= (lit.neg ? 2'd3 : 2'd2)) begin
          fold_digit(r.symbol);
        end
      end
      if (lit.pos != POS_MAX) lit.pos = lit.pos + 2'd1;
    end
    if (r.last) begin
      v = lit.neg ? (~lit.mag + 1'b1) : lit.mag;
      res.value        = signed'(v);
      res.overflow     = lit.sat;
      res.digits_found = lit.seen_digit;
      lit = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ------------------------------------------------------------- stimulus --
  task automatic push_char(logic [7:0] c, mode_t m, bit fin);
    in_t r;
    r.symbol = c;
    r.mode   = m;
    r.last   = fin;
    char_backlog.push_back(r);
    chars_queued++;
  endtask

  task automatic queue_text(string s, mode_t m);
    for (int i = 0; i < s.len(); i++) push_char(s[i], m, i == s.len() - 1);
  endtask

  function automatic logic [7:0] digit_char(int d, bit upper);
    if (d < 10) return 8'("0" + d);
    return 8'((upper ? "A" : "a") + d - 10);
  endfunction

  // Sign, prefix, digits with underscores, maybe a stop character and junk
  task automatic queue_wellformed();
    mode_t      m;
    logic [7:0] txt[$];
    logic [7:0] marker;
    int         ndig, radix, k;
    m     = mode_t'($urandom_range(3));
    radix = base_radix(m);
    if ($urandom_range(7) == 0) txt.push_back(CH_UNDERSCORE);
    if (m == MODE_DEC) begin
      k = $urandom_range(3);
      if (k == 0) txt.push_back(CH_MINUS);
      else if (k == 1) txt.push_back(CH_PLUS);
    end else begin
      if ($urandom_range(2) == 0) txt.push_back(CH_MINUS);
      if ($urandom_range(7) == 0) begin
        txt.push_back(8'($urandom_range(255)));
        txt.push_back(8'($urandom_range(255)));
      end else begin
        case (m)
          MODE_BIN: marker = "b";
          MODE_OCT: marker = "o";
          default:  marker = "x";
        endcase
        if ($urandom_range(3) == 0) marker = marker - 8'h20;
        txt.push_back("0");
        txt.push_back(marker);
      end
    end
    // mostly short, sometimes long enough to reach the range limit
    if ($urandom_range(9) < 7) begin
      ndig = $urandom_range(6, 1);
    end else begin
      case (m)
        MODE_DEC: ndig = $urandom_range(22, 17);
        MODE_BIN: ndig = $urandom_range(66, 58);
        MODE_OCT: ndig = $urandom_range(24, 19);
        default:  ndig = $urandom_range(18, 14);
      endcase
    end
    for (k = 0; k < ndig; k++) begin
      if ($urandom_range(7) == 0) txt.push_back(CH_UNDERSCORE);
      txt.push_back(digit_char($urandom_range(radix - 1), 1'($urandom_range(1))));
    end
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       txt.push_back(" ");
        1:       txt.push_back(CH_PLUS);
        2:       txt.push_back(CH_MINUS);
        default: txt.push_back(".");
      endcase
      repeat ($urandom_range(3)) txt.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(9) == 0) txt.push_back(CH_UNDERSCORE);
    foreach (txt[i]) begin
      push_char(txt[i], ($urandom_range(9) == 0) ? mode_t'($urandom_range(3)) : m,
                i == txt.size() - 1);
    end
  endtask

  task automatic queue_noise();
    int n;
    n = $urandom_range(6, 1);
    for (int k = 0; k < n; k++) begin
      push_char(8'($urandom_range(255)), mode_t'($urandom_range(3)), k == n - 1);
    end
  endtask

  task automatic queue_random(int n_chars);
    int stop_at, pick;
    stop_at = chars_queued + n_chars;
    while (chars_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        queue_wellformed();
      end else if (pick < 82) begin
        pick = $urandom_range(7);
        queue_text(brink_text[pick], brink_mode[pick]);
      end else begin
        queue_noise();
      end
    end
  endtask

  // Wait until every request has gone in and every result has come back
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (char_backlog.size() != 0 || in_valid || awaited_values.size() != 0);
  endtask

  task automatic note_mismatch(string what);
    err_count++;
    if (err_count <= 100) $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // --------------------------------------------------------------- driver --
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (char_backlog.size() != 0 && (calm || $urandom_range(99) >= 11)) begin
        in_data  <= char_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side ready, with random gaps and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  // -------------------------------------------------------------- monitor --
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) begin
      req_taken = 1'b1;
      if (parse_char(in_data, fresh)) awaited_values.push_back(fresh);
    end
    if (!rst && out_valid && out_ready) begin
      got = out_data;
      if (awaited_values.size() == 0) begin
        note_mismatch($sformatf("result with none expected, value %0d", got.value));
      end else begin
        want = awaited_values.pop_front();
        if (got.value !== want.value)
          note_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
        if (got.overflow !== want.overflow)
          note_mismatch($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
        if (got.digits_found !== want.digits_found)
          note_mismatch($sformatf("digits_found %b, expected %b",
                                  got.digits_found, want.digits_found));
      end
    end
  end

  // ---------------------------------------------------------------- phases --
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sign alone, plus sign, prefix only, negative hex with underscore
    queue_text("-", MODE_DEC);
    queue_text("+9", MODE_DEC);
    queue_text("0x", MODE_HEX);
    queue_text("-0x_F", MODE_HEX);
    // digits stop at the first invalid character
    queue_text("12a3", MODE_DEC);
    // base latched on the first character, later mode changes ignored
    push_char("0", MODE_OCT, 1'b0);
    push_char("o", MODE_HEX, 1'b0);
    push_char("7", MODE_BIN, 1'b0);
    push_char("Z", MODE_DEC, 1'b1);
    // underscore as the closing character, then a binary prefix with no digits
    queue_text("_", MODE_HEX);
    queue_text("7_", MODE_DEC);
    queue_text("0bz", MODE_BIN);
    wait_drained();

    // long result-side hold-off while requests keep coming
    hold_req = 1'b1;
    queue_random(300);
    wait_drained();

    // stretch with no idling on either side
    calm = 1'b1;
    queue_random(400);
    wait_drained();
    calm = 1'b0;

    queue_random(400);
    wait_drained();
    repeat (8) @(posedge clk);

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
